[hw/rtl/smbw_pkg.sv]
// Shared types and constants for the SMBIOS structure table length walker.
package smbw_pkg;

  localparam logic [7:0] END_TYPE     = 8'd127;
  localparam logic [7:0] HEADER_BYTES = 8'd4;
  localparam logic [31:0] MAX_LENGTH_RESET = 32'd65535;

  typedef enum logic [1:0] {
    ST_WALKING   = 2'd0,
    ST_COMPLETE  = 2'd1,
    ST_MALFORMED = 2'd2,
    ST_OVERRUN   = 2'd3
  } status_t;

  typedef enum logic [4:0] {
    PH_TYPE      = 5'b00001,
    PH_LENGTH    = 5'b00010,
    PH_FORMATTED = 5'b00100,
    PH_STRINGS   = 5'b01000,
    PH_DONE      = 5'b10000
  } phase_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] table_length;
  } result_t;

endpackage

[hw/rtl/smbw_core.sv]
// Walk state and per-byte next-state logic of the structure table walker.
module smbw_core #(
  parameter int LENGTH_BITS = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   step,
  input  logic [7:0]             data_byte,
  input  logic                   start_req,
  input  logic [LENGTH_BITS-1:0] max_length,
  output smbw_pkg::result_t      result
);
  import smbw_pkg::*;

  localparam int L = LENGTH_BITS;

  logic [L-1:0] byte_position, byte_position_next;
  logic [L-1:0] strings_start, strings_start_next;
  phase_t       walk_phase, walk_phase_next;
  logic         end_seen, end_seen_next;
  logic         previous_zero, previous_zero_next;
  status_t      final_status, final_status_next;

  // State as seen by this byte: a start mark clears the walk first.
  logic [L-1:0] p_eff;
  logic [L-1:0] ss_eff;
  phase_t       ph_eff;
  logic         es_eff;
  logic         pz_eff;
  status_t      st_eff;

  logic [L:0]   p_ext;
  logic [L:0]   mx_ext;
  logic [L:0]   p_plus1;
  logic [L:0]   p_plus4;
  logic [L:0]   ss_wide;
  logic [L+1:0] ss_check;

  always_comb begin
    p_eff  = start_req ? '0 : byte_position;
    ss_eff = start_req ? '0 : strings_start;
    ph_eff = start_req ? PH_TYPE : walk_phase;
    es_eff = start_req ? 1'b0 : end_seen;
    pz_eff = start_req ? 1'b0 : previous_zero;
    st_eff = start_req ? ST_WALKING : final_status;

    p_ext    = {1'b0, p_eff};
    mx_ext   = {1'b0, max_length};
    p_plus1  = p_ext + (L+1)'(1);
    p_plus4  = p_ext + (L+1)'(HEADER_BYTES);
    ss_wide  = p_ext - (L+1)'(1) + (L+1)'(data_byte);
    ss_check = {1'b0, ss_wide} + (L+2)'(1);

    byte_position_next = p_eff;
    strings_start_next = ss_eff;
    walk_phase_next    = ph_eff;
    end_seen_next      = es_eff;
    previous_zero_next = pz_eff;
    final_status_next  = st_eff;

    unique case (ph_eff)
      PH_TYPE: begin
        // No room left for a four-byte header.
        if (p_plus4 > mx_ext) begin
          final_status_next = ST_OVERRUN;
          walk_phase_next   = PH_DONE;
        end else begin
          end_seen_next      = (data_byte == END_TYPE);
          walk_phase_next    = PH_LENGTH;
          byte_position_next = p_plus1[L-1:0];
        end
      end
      PH_LENGTH: begin
        if (data_byte < HEADER_BYTES) begin
          final_status_next = ST_MALFORMED;
          walk_phase_next   = PH_DONE;
        end else if (ss_check >= {1'b0, mx_ext}) begin
          final_status_next = ST_OVERRUN;
          walk_phase_next   = PH_DONE;
        end else begin
          strings_start_next = ss_wide[L-1:0];
          walk_phase_next    = PH_FORMATTED;
          byte_position_next = p_plus1[L-1:0];
        end
      end
      PH_FORMATTED: begin
        if (p_plus1 >= {1'b0, ss_eff}) begin
          walk_phase_next    = PH_STRINGS;
          previous_zero_next = 1'b0;
        end
        byte_position_next = p_plus1[L-1:0];
      end
      PH_STRINGS: begin
        if (data_byte == 8'd0 && pz_eff) begin
          previous_zero_next = 1'b0;
          byte_position_next = p_plus1[L-1:0];
          if (es_eff) begin
            final_status_next = ST_COMPLETE;
            walk_phase_next   = PH_DONE;
          end else begin
            walk_phase_next = PH_TYPE;
          end
        end else if (p_plus1 >= mx_ext) begin
          // Last byte of the table consumed without closing the string set.
          final_status_next = ST_OVERRUN;
          walk_phase_next   = PH_DONE;
        end else begin
          previous_zero_next = (data_byte == 8'd0);
          byte_position_next = p_plus1[L-1:0];
        end
      end
      PH_DONE: begin
      end
      default: begin
      end
    endcase

    result.status       = final_status_next;
    result.table_length = (final_status_next == ST_COMPLETE) ?
                          32'(byte_position_next) : 32'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      strings_start <= '0;
      walk_phase    <= PH_TYPE;
      end_seen      <= 1'b0;
      previous_zero <= 1'b0;
      final_status  <= ST_WALKING;
    end else if (step) begin
      byte_position <= byte_position_next;
      strings_start <= strings_start_next;
      walk_phase    <= walk_phase_next;
      end_seen      <= end_seen_next;
      previous_zero <= previous_zero_next;
      final_status  <= final_status_next;
    end
  end

endmodule

[hw/rtl/smbios_table_length_walker.sv]
// Top level of the SMBIOS structure table length walker: stream ports and registers.
// Path: a byte accepted into the input register passes the combinational walk logic
// into the result register once that is free or being drained; m_tvalid then rises.
// Throughput: one byte per cycle while the result register is free or drained;
// the walk state steps once per accepted byte. Reset: rst (synchronous) empties
// both registers, restarts the walk at offset zero and sets max_length to 65535.
module smbios_table_length_walker #(
  parameter int LENGTH_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  // s_tdata: data_byte [7:0]
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,
  // s_tuser: start_req [0]
  input  logic        s_tuser,
  // m_tdata: status [1:0], table_length [33:2], zero fill [39:34]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);
  import smbw_pkg::*;

  logic        in_valid;
  logic [7:0]  in_byte;
  logic        in_start;
  logic        out_valid;
  result_t     out_result;
  result_t     core_result;
  logic [31:0] max_length;
  logic        advance;

  // A request moves forward when the result register is free or being drained.
  assign advance   = in_valid && (!out_valid || m_tready);
  assign s_tready  = !in_valid || advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_length <= MAX_LENGTH_RESET;
    end else if (cfg_valid) begin
      max_length <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte  <= s_tdata;
      in_start <= s_tuser;
    end
  end

  smbw_core #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .step       (advance),
    .data_byte  (in_byte),
    .start_req  (in_start),
    .max_length (max_length[LENGTH_BITS-1:0]),
    .result     (core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= core_result;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {6'd0, out_result.table_length, out_result.status};

endmodule
